// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hdl/gbn_pkg.sv -----
package gbn_pkg;

    localparam int MAX_WINDOW_DEF = 32;
    localparam int CMDQ_DEPTH     = 4;

    localparam logic [31:0] TOTAL_CAP = 32'hFFFF_FFFE;

    localparam logic [1:0] MODE_START   = 2'd0;
    localparam logic [1:0] MODE_TIMEOUT = 2'd1;
    localparam logic [1:0] MODE_ACK     = 2'd2;

    localparam logic [1:0] ST_SEND     = 2'd0;
    localparam logic [1:0] ST_IDLE     = 2'd1;
    localparam logic [1:0] ST_COMPLETE = 2'd2;
    localparam logic [1:0] ST_FAILED   = 2'd3;

    localparam logic [1:0] CFG_WINDOW = 2'd0;
    localparam logic [1:0] CFG_TOTAL  = 2'd1;
    localparam logic [1:0] CFG_RETRY  = 2'd2;

    localparam logic [5:0] WINDOW_RST = 6'd1;
    localparam logic [3:0] RETRY_RST  = 4'd3;

    // One queued job for the emitter: a single report or a run of sequence numbers.
    typedef struct packed {
        logic        single;
        logic [31:0] seq_first;
        logic [31:0] seq_last;
        logic [1:0]  status;
        logic [4:0]  mult;
    } t_cmd;

endpackage

// ----- hdl/gbn_front.sv -----
module gbn_front #(
    parameter int MAX_WINDOW = gbn_pkg::MAX_WINDOW_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_mode,
    input  logic [31:0]       i_req,
    output logic              o_push,
    output gbn_pkg::t_cmd     o_cmd,
    input  logic              i_full
);
    import gbn_pkg::*;

    localparam int WW = $clog2(MAX_WINDOW + 1);

    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_EXEC  = 2'd1;
    localparam logic [1:0] F_LIMIT = 2'd2;
    localparam logic [1:0] F_PUSH  = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [5:0]  r_window;
    logic [31:0] r_total;
    logic [3:0]  r_rlimit;
    logic [1:0]  r_mode;
    logic [31:0] r_req;
    logic [31:0] r_base, n_base;
    logic [31:0] r_next, n_next;
    logic [3:0]  r_retry, n_retry;
    logic        r_active, n_active;
    logic        r_complete, n_complete;
    logic        r_failed, n_failed;
    logic        r_single, n_single;
    logic [1:0]  r_stat, n_stat;
    logic [31:0] r_end, n_end;

    logic [WW-1:0] w_eff;
    logic [32:0]   limit;
    logic [31:0]   total_eff;
    logic [3:0]    retry_inc;
    logic [3:0]    rlimit_eff;
    logic          req_done;
    logic          has_room;

    always_comb begin
        if (r_window == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_window) > 32'(MAX_WINDOW)) begin
            w_eff = WW'(MAX_WINDOW);
        end else begin
            w_eff = WW'(r_window);
        end
        total_eff  = (r_total == '1) ? TOTAL_CAP : r_total;
        limit      = {1'b0, r_base} + 33'(w_eff) - 33'd1;
        retry_inc  = r_retry + 4'd1;
        rlimit_eff = (r_rlimit == '0) ? 4'd1 : r_rlimit;
        req_done   = ({1'b0, r_req} == ({1'b0, total_eff} + 33'd1));
        has_room   = (r_next <= r_end);
    end

    always_comb begin
        n_state    = r_state;
        n_base     = r_base;
        n_next     = r_next;
        n_retry    = r_retry;
        n_active   = r_active;
        n_complete = r_complete;
        n_failed   = r_failed;
        n_single   = r_single;
        n_stat     = r_stat;
        n_end      = r_end;
        o_push     = 1'b0;
        o_cmd      = '0;
        o_cmd.mult = {1'b0, r_retry} + 5'd1;
        unique case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_state = F_EXEC;
                end
            end
            F_EXEC: begin
                n_single = 1'b1;
                n_state  = F_PUSH;
                priority if (r_mode == MODE_START) begin
                    n_base     = 32'd1;
                    n_next     = 32'd1;
                    n_retry    = '0;
                    n_active   = 1'b1;
                    n_complete = 1'b0;
                    n_failed   = 1'b0;
                    n_single   = 1'b0;
                    n_state    = F_LIMIT;
                end else if (r_mode == MODE_TIMEOUT && r_active) begin
                    n_retry = retry_inc;
                    if (retry_inc >= rlimit_eff) begin
                        n_active = 1'b0;
                        n_failed = 1'b1;
                        n_stat   = ST_FAILED;
                    end else begin
                        n_next   = r_base;
                        n_single = 1'b0;
                        n_state  = F_LIMIT;
                    end
                end else if (r_mode == MODE_ACK && r_active) begin
                    if (req_done) begin
                        n_active   = 1'b0;
                        n_complete = 1'b1;
                        n_stat     = ST_COMPLETE;
                    end else begin
                        n_base   = (r_req > r_base) ? r_req : r_base;
                        n_retry  = '0;
                        n_single = 1'b0;
                        n_state  = F_LIMIT;
                    end
                end else begin
                    n_stat = r_complete ? ST_COMPLETE : (r_failed ? ST_FAILED : ST_IDLE);
                end
            end
            F_LIMIT: begin
                if (r_next < r_base) begin
                    n_next = r_base;
                end
                n_end   = (limit > {1'b0, total_eff}) ? total_eff : limit[31:0];
                n_state = F_PUSH;
            end
            F_PUSH: begin
                if (r_single) begin
                    o_cmd.single = 1'b1;
                    o_cmd.status = r_stat;
                end else if (has_room) begin
                    o_cmd.seq_first = r_next;
                    o_cmd.seq_last  = r_end;
                    o_cmd.status    = ST_SEND;
                end else begin
                    o_cmd.single = 1'b1;
                    o_cmd.status = ST_IDLE;
                end
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                    if (!r_single && has_room) begin
                        n_next = r_end + 32'd1;
                    end
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    assign o_ready = (r_state == F_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= F_IDLE;
            r_window   <= WINDOW_RST;
            r_total    <= '0;
            r_rlimit   <= RETRY_RST;
            r_base     <= 32'd1;
            r_next     <= 32'd1;
            r_retry    <= '0;
            r_active   <= 1'b0;
            r_complete <= 1'b0;
            r_failed   <= 1'b0;
            r_single   <= 1'b0;
            r_stat     <= ST_IDLE;
        end else begin
            r_state    <= n_state;
            r_base     <= n_base;
            r_next     <= n_next;
            r_retry    <= n_retry;
            r_active   <= n_active;
            r_complete <= n_complete;
            r_failed   <= n_failed;
            r_single   <= n_single;
            r_stat     <= n_stat;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_WINDOW: r_window <= i_cfg_data[5:0];
                    CFG_TOTAL:  r_total  <= i_cfg_data;
                    CFG_RETRY:  r_rlimit <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_end <= n_end;
        if (i_valid && o_ready) begin
            r_mode <= i_mode;
            r_req  <= i_req;
        end
    end

endmodule

// ----- hdl/gbn_cmdq.sv -----
`include "assert_macros.svh"

module gbn_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gbn_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output gbn_pkg::t_cmd o_cmd
);
    import gbn_pkg::*;

    localparam int PW = $clog2(CMDQ_DEPTH);
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    t_cmd          r_mem [CMDQ_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(CMDQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    `ASSERT_CLK(a_count_bound, r_count <= CW'(CMDQ_DEPTH), "queue count beyond depth")
    `ASSERT_CLK(a_push_grows, do_push && !do_pop |=> r_count == $past(r_count) + CW'(1), "push lost")
    `ASSERT_CLK(a_pop_shrinks, do_pop && !do_push |=> r_count == $past(r_count) - CW'(1), "pop lost")

endmodule

// ----- hdl/gbn_back.sv -----
`include "assert_macros.svh"

module gbn_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  gbn_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [31:0]   o_seq,
    output logic [1:0]    o_status,
    output logic [4:0]    o_mult,
    output logic          o_last
);
    import gbn_pkg::*;

    logic        r_busy;
    logic        r_single;
    logic [31:0] r_cur;
    logic [31:0] r_end;
    logic [1:0]  r_stat;
    logic [4:0]  r_mult;
    logic        r_out_valid;
    logic [31:0] r_out_seq;
    logic [1:0]  r_out_status;
    logic [4:0]  r_out_mult;
    logic        r_out_last;
    logic        load;
    logic        last_now;

    assign o_pop    = !r_busy && i_valid;
    assign load     = r_busy && (!r_out_valid || i_ready);
    assign last_now = r_single || (r_cur == r_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (load && last_now) begin
                r_busy <= 1'b0;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_single <= i_cmd.single;
            r_cur    <= i_cmd.seq_first;
            r_end    <= i_cmd.seq_last;
            r_stat   <= i_cmd.status;
            r_mult   <= i_cmd.mult;
        end else if (load) begin
            r_cur <= r_cur + 32'd1;
        end
        if (load) begin
            r_out_seq    <= r_cur;
            r_out_status <= r_stat;
            r_out_mult   <= r_mult;
            r_out_last   <= last_now;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_seq    = r_out_seq;
    assign o_status = r_out_status;
    assign o_mult   = r_out_mult;
    assign o_last   = r_out_last;

    `ASSERT_CLK(a_run_order, r_busy && !r_single |-> r_cur <= r_end, "run passed its end")
    `ASSERT_CLK(a_report_last, r_out_valid && r_out_status != ST_SEND |-> r_out_last, "report not last")
    `ASSERT_CLK(a_pop_idle, o_pop |=> r_busy, "job taken without starting")

endmodule

// ----- hdl/go_back_n_sender_window_core.sv -----
// Channel   Direction  Handshake                     Payload
// events    in         i_s_tvalid / o_s_tready       tuser: mode; tdata: request_number
// results   out        o_m_tvalid / i_m_tready       tdata, tuser: status, tlast
// config    in         i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// The front steps through accept, state update, window limit and queue push for an event
// that sends a window, and skips the window limit for an event that gives a single report.
// The back emits one result per cycle while i_m_tready holds, and pops the next job only once the current one is done.
// A four-entry job queue lets the front run ahead while the result side stalls; when it is
// full the front holds in its push step and o_s_tready stays low.
// Synchronous reset clears the window state and loads the register defaults; no clearing pass.
module go_back_n_sender_window_core #(
    parameter int MAX_WINDOW = gbn_pkg::MAX_WINDOW_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // [31:0] request_number
    input  logic [1:0]  i_s_tuser,  // [1:0] mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,  // [31:0] send_sequence, [36:32] timeout_multiplier
    output logic [1:0]  o_m_tuser,  // [1:0] status
    output logic        o_m_tlast   // last_result
);
    import gbn_pkg::*;

    logic        push;
    logic        full;
    logic        pop;
    logic        q_valid;
    t_cmd        push_cmd;
    t_cmd        head_cmd;
    logic [31:0] seq;
    logic [4:0]  mult;

    assign o_cfg_ready = 1'b1;

    gbn_front #(
        .MAX_WINDOW(MAX_WINDOW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_mode     (i_s_tuser),
        .i_req      (i_s_tdata),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .i_full     (full)
    );

    gbn_cmdq u_cmdq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .o_full (full),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_cmd  (head_cmd)
    );

    gbn_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_seq   (seq),
        .o_status(o_m_tuser),
        .o_mult  (mult),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = {3'b000, mult, seq};

endmodule
